### rtl/core/b2da_pkg.sv
package b2da_pkg;

	// Width of the value that is converted; bits of the input above it are ignored.
	localparam int VALUE_BITS = 64;

	// Decimal digits needed for the largest magnitude (ceil of VALUE_BITS * log10(2)).
	localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;

	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

	// ASCII codes that appear on the character output.
	localparam logic [5:0] ASCII_ZERO  = 6'd48;
	localparam logic [5:0] ASCII_MINUS = 6'd45;

	// Values of a decimal digit that matter to the adjust step.
	localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [3:0] DIGIT_ADJ_ADD = 4'd3;
	localparam logic [3:0] DIGIT_MAX     = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} b2da_state_t;

	// Control that every digit cell of the chain sees in the same cycle.
	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift_digit;
	} cell_ctrl_t;

endpackage

### rtl/core/b2da_cell.sv
module b2da_cell
	import b2da_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       carry_in,
	input  logic [3:0] digit_in,
	output logic       carry_out,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three to a digit of five or more so that the next doubling carries correctly.
	assign adj       = (digit_q >= DIGIT_ADJ_MIN) ? (digit_q + DIGIT_ADJ_ADD) : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	// Digit register: cleared at the start, doubled with the carry from below, or
	// loaded from the lower neighbor while the text is read out.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.shift_digit) begin
			digit_q <= digit_in;
		end
	end

endmodule

### rtl/core/binary_to_decimal_ascii_core.sv
// Converts one 64-bit value, unsigned or two's complement signed as func selects, into
// its decimal ASCII text, one character per output request, most significant digit first,
// with no leading zeros; zero gives a single '0', a negative value first gives '-', and
// last_char marks the final character. An item first takes the shift-and-add-3 pass
// through a chain of 20 BCD digit cells (one input bit per cycle), then skips the
// leading zero digits, then gives out its characters, each taken while out_stall is
// low. Skipped zeros and printed digits always add up to 20. After the last character
// the block returns to idle, where the next request can be accepted. The block
// holds one item at a time: in_stall stays high from acceptance until the last character
// is taken.
module binary_to_decimal_ascii_core
	import b2da_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  char_code,
	output logic        last_char
);

	b2da_state_t             state_q, state_nxt;
	logic [VALUE_BITS-1:0]   mag_q;
	logic                    neg_q;
	logic [BIT_CNT_W-1:0]    bit_cnt_q;
	logic [DIG_CNT_W-1:0]    dig_cnt_q;

	logic [VALUE_BITS-1:0]   value_w;
	logic                    is_neg;
	logic [VALUE_BITS-1:0]   mag;
	logic                    in_acc;
	logic                    out_acc;
	logic                    top_zero;
	logic                    last_digit;
	cell_ctrl_t              ctrl;
	logic [NUM_DIGITS:0]     carry;
	logic [3:0]              digits [NUM_DIGITS];

	// Magnitude of the incoming value; the most negative value negates to itself.
	assign value_w = value[VALUE_BITS-1:0];
	assign is_neg  = func & value_w[VALUE_BITS-1];
	assign mag     = is_neg ? (~value_w + VALUE_BITS'(1)) : value_w;

	assign in_acc     = in_valid & ~in_stall;
	assign out_acc    = out_valid & ~out_stall;
	assign top_zero   = (digits[NUM_DIGITS-1] == 4'd0);
	assign last_digit = (dig_cnt_q == DIG_CNT_W'(1));

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (bit_cnt_q == '0) state_nxt = neg_q ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: begin
				if (out_acc) state_nxt = ST_SKIP;
			end
			ST_SKIP: begin
				if (!top_zero || last_digit) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && last_digit) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs and cell control.
	always_comb begin
		in_stall         = 1'b1;
		out_valid        = 1'b0;
		char_code        = ASCII_ZERO + {2'b00, digits[NUM_DIGITS-1]};
		last_char        = 1'b0;
		ctrl.clear       = 1'b0;
		ctrl.dabble      = 1'b0;
		ctrl.shift_digit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				ctrl.clear = in_valid;
			end
			ST_CONV: begin
				ctrl.dabble = 1'b1;
			end
			ST_SIGN: begin
				out_valid = 1'b1;
				char_code = ASCII_MINUS;
			end
			ST_SKIP: begin
				ctrl.shift_digit = top_zero & ~last_digit;
			end
			ST_EMIT: begin
				out_valid        = 1'b1;
				last_char        = last_digit;
				ctrl.shift_digit = ~out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1);
				dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
			end else begin
				if (state_q == ST_CONV) bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
				if (ctrl.shift_digit) dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
			end
		end
	end

	// Magnitude shift register, feeding its top bit into the digit chain.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= mag;
			neg_q <= is_neg;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign carry[0] = mag_q[VALUE_BITS-1];

	// Chain of BCD digit cells; cell 0 holds the least significant digit.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic [3:0] digit_from_below;
		if (i == 0) begin : g_first
			assign digit_from_below = 4'd0;
		end else begin : g_rest
			assign digit_from_below = digits[i-1];
		end
		b2da_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.digit_in  (digit_from_below),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

	// The top cell must never overflow: the magnitude always fits the digit count.
	a_no_top_carry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> !carry[NUM_DIGITS])
		else $error("digit chain overflow during conversion");

	// A character shown as a digit is a valid decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> digits[NUM_DIGITS-1] <= DIGIT_MAX)
		else $error("emitted digit out of range");

	// Readout starts on a nonzero digit unless only one digit is left.
	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> (!top_zero || last_digit))
		else $error("leading zero emitted");

	// The minus sign appears only for a negative signed value.
	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIGN |-> neg_q)
		else $error("sign emitted for non-negative value");

	// An accepted request always starts a conversion pass.
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_CONV)
		else $error("accepted request did not start conversion");

endmodule
